/* rtl/rrbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rrbd_pkg;

  localparam int unsigned CntW = 8;
  localparam int unsigned ChW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned NumBtn = 4;

  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [7:0] RstUpdownThr    = 8'd10;
  localparam logic [7:0] RstStartstopThr = 8'd5;
  localparam logic [7:0] RstChMin        = 8'd3;
  localparam logic [7:0] RstChMax        = 8'd18;
  localparam logic [7:0] RstChStart      = 8'd3;

  localparam logic [1:0] BtnUp    = 2'd0;
  localparam logic [1:0] BtnDown  = 2'd1;
  localparam logic [1:0] BtnStart = 2'd2;
  localparam logic [1:0] BtnStop  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgUpdownThr    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartstopThr = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChMin        = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChMax        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChStart      = 3'd4;

  typedef struct packed {
    logic level_up;
    logic level_down;
    logic level_start;
    logic level_stop;
  } in_word_t;

  typedef struct packed {
    logic [ChW-1:0] channel;
    logic           running;
    logic [1:0]     serviced_button;
  } out_word_t;

  typedef struct packed {
    logic [CntW-1:0] updown_thr;
    logic [CntW-1:0] startstop_thr;
    logic [ChW-1:0]  ch_min;
    logic [ChW-1:0]  ch_max;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]        scan;
    logic [NumBtn-1:0] latched;
  } core_stat_t;

endpackage

`default_nettype wire

/* rtl/rrbd_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrbd_cfg
  import rrbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_regs_t                cfg_regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // The start channel only matters at reset, and reset restores its default,
  // so a write to it has no lasting effect and needs no storage.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        CfgUpdownThr:    regs_nxt.updown_thr    = cfg_wdata;
        CfgStartstopThr: regs_nxt.startstop_thr = cfg_wdata;
        CfgChMin:        regs_nxt.ch_min        = cfg_wdata;
        CfgChMax:        regs_nxt.ch_max        = cfg_wdata;
        CfgChStart:      regs_nxt = regs_r;
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.updown_thr    <= RstUpdownThr;
      regs_r.startstop_thr <= RstStartstopThr;
      regs_r.ch_min        <= RstChMin;
      regs_r.ch_max        <= RstChMax;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_regs = regs_r;

endmodule

`default_nettype wire

/* rtl/rrbd_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrbd_core
  import rrbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_word_t  in_word,
  input  wire cfg_regs_t cfg_regs,
  output out_word_t result,
  output core_stat_t stat
);

  logic [1:0]        scan_r,  scan_nxt;
  logic [CntW-1:0]   cnt_r [NumBtn];
  logic [CntW-1:0]   cnt_nxt;
  logic [NumBtn-1:0] lat_r,   lat_nxt;
  logic [ChW-1:0]    chan_r,  chan_nxt;
  logic              run_r,   run_nxt;

  logic            pressed;
  logic [CntW-1:0] thr;
  logic [CntW-1:0] cnt_cur;
  logic [CntW-1:0] cnt_inc;
  logic            fire;
  logic [ChW:0]    up_val;
  logic [ChW:0]    min_plus1;

  always_comb begin
    case (scan_r)
      BtnUp:    pressed = !in_word.level_up;
      BtnDown:  pressed = !in_word.level_down;
      BtnStart: pressed = !in_word.level_start;
      BtnStop:  pressed = !in_word.level_stop;
      default:  pressed = 1'b0;
    endcase
  end

  assign thr     = (scan_r == BtnUp || scan_r == BtnDown) ?
                   cfg_regs.updown_thr : cfg_regs.startstop_thr;
  assign cnt_cur = cnt_r[scan_r];
  assign cnt_inc = (cnt_cur == CntMax) ? cnt_cur : cnt_cur + 1'b1;

  assign up_val    = {1'b0, chan_r} + 1'b1;
  assign min_plus1 = {1'b0, cfg_regs.ch_min} + 1'b1;

  always_comb begin
    cnt_nxt  = cnt_cur;
    lat_nxt  = lat_r;
    chan_nxt = chan_r;
    run_nxt  = run_r;
    fire     = 1'b0;
    scan_nxt = scan_r + 1'b1;
    if (pressed && !lat_r[scan_r]) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc > thr) begin
        lat_nxt[scan_r] = 1'b1;
        fire            = 1'b1;
      end
    end else if (!pressed && lat_r[scan_r]) begin
      cnt_nxt         = '0;
      lat_nxt[scan_r] = 1'b0;
    end
    if (fire) begin
      case (scan_r)
        BtnUp: begin
          if (up_val >= {1'b0, cfg_regs.ch_max}) begin
            chan_nxt = cfg_regs.ch_max;
          end else begin
            chan_nxt = up_val[ChW-1:0];
          end
        end
        BtnDown: begin
          if ({1'b0, chan_r} <= min_plus1) begin
            chan_nxt = cfg_regs.ch_min;
          end else begin
            chan_nxt = chan_r - 1'b1;
          end
        end
        BtnStart: run_nxt = 1'b1;
        BtnStop:  run_nxt = 1'b0;
        default:  run_nxt = run_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= BtnUp;
      lat_r  <= '0;
      chan_r <= RstChStart;
      run_r  <= 1'b0;
      for (int i = 0; i < NumBtn; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      scan_r         <= scan_nxt;
      lat_r          <= lat_nxt;
      chan_r         <= chan_nxt;
      run_r          <= run_nxt;
      cnt_r[scan_r]  <= cnt_nxt;
    end
  end

  assign result.channel         = chan_nxt;
  assign result.running         = run_nxt;
  assign result.serviced_button = scan_r;

  assign stat.scan    = scan_r;
  assign stat.latched = lat_r;

endmodule

`default_nettype wire

/* rtl/round_robin_button_debounce_channel_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_ready   in_data   (in_word_t)
// out_     output     out_valid / out_ready out_data  (out_word_t)
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One word per clock cycle sustained while out_ready is high; a word waiting in
// the input register moves to the result register once it is empty or read.
// The debounce state is updated as a word moves from the input register into
// the result register, so each word sees the state left by the one before it.
// Reset is synchronous and active low; it restores the register defaults,
// clears all press counters and latches and loads the start channel.
// A stalled out_ready holds the result register and, once the input register
// is also full, drops in_ready.

module round_robin_button_debounce_channel_top
  import rrbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_word_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_word_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  logic       s1_valid_r, s1_valid_nxt;
  in_word_t   s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r;
  logic       adv;
  cfg_regs_t  cfg_regs;
  out_word_t  core_result;
  core_stat_t core_stat;

  rrbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_regs  (cfg_regs)
  );

  rrbd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .in_word  (s1_data_r),
    .cfg_regs (cfg_regs),
    .result   (core_result),
    .stat     (core_stat)
  );

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded after a word left the input register");

  a_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register lost a waiting word");

  a_scan_steps : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> core_stat.scan == $past(core_stat.scan) + 2'd1)
    else $error("scan position did not advance by one button");

  a_scan_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(core_stat.scan) && $stable(core_stat.latched))
    else $error("debounce state changed without a word");

endmodule

`default_nettype wire

/* sim/tb_round_robin_button_debounce_channel_top.sv */
`timescale 1ns / 1ps

module tb_round_robin_button_debounce_channel_top;
  import rrbd_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd5;
  localparam int RandomWords = 1150;

  typedef struct {
    bit                   is_cfg;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    in_word_t             word;
    bit                   has_want;
    out_word_t            want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  // Shadow of the debounce state and register file.
  logic [1:0]     scan_pos;
  logic [CntW-1:0] press_cnt [NumBtn];
  bit             latch_q [NumBtn];
  logic [ChW-1:0] chan;
  bit             run;
  logic [7:0]     thr_updown;
  logic [7:0]     thr_startstop;
  logic [7:0]     ch_lo;
  logic [7:0]     ch_hi;
  logic [7:0]     ch_start;

  out_word_t pending_status[$];
  out_word_t status_want;
  stim_row_t plan[$];
  int        mismatch_cnt;
  bit        no_idle;

  round_robin_button_debounce_channel_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 7) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_reg_value(input logic [CfgIdxW-1:0] idx);
    int r;
    r = $urandom_range(0, 9);
    case (idx)
      CfgUpdownThr, CfgStartstopThr: begin
        if (r < 6) return CfgDataW'($urandom_range(0, 4));
        if (r < 8) return CfgDataW'($urandom_range(5, 15));
        if (r == 8) return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd254;
        return CfgDataW'($urandom_range(0, 254));
      end
      CfgChMin, CfgChMax: begin
        if (r < 7) return CfgDataW'($urandom_range(0, 40));
        if (r == 7) return 8'd0;
        if (r == 8) return 8'd255;
        return CfgDataW'($urandom_range(0, 255));
      end
      default: return CfgDataW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic debounce_tick(input in_word_t w, output out_word_t res);
    logic [1:0] btn;
    logic [3:0] lv;
    bit         pressed;
    logic [7:0] thr;
    int         v;
    btn = scan_pos;
    lv = {w.level_stop, w.level_start, w.level_down, w.level_up};
    pressed = !lv[btn];
    thr = (btn == BtnUp || btn == BtnDown) ? thr_updown : thr_startstop;
    if (pressed && !latch_q[btn]) begin
      if (press_cnt[btn] != CntMax) press_cnt[btn] = press_cnt[btn] + 1'b1;
      if (press_cnt[btn] > thr) begin
        latch_q[btn] = 1'b1;
        case (btn)
          BtnUp: begin
            v = int'(chan) + 1;
            if (v >= int'(ch_hi)) v = int'(ch_hi);
            chan = v[7:0];
          end
          BtnDown: begin
            v = int'(chan) - 1;
            if (v <= int'(ch_lo)) v = int'(ch_lo);
            chan = v[7:0];
          end
          BtnStart: run = 1'b1;
          default: run = 1'b0;
        endcase
      end
    end else if (!pressed && latch_q[btn]) begin
      press_cnt[btn] = '0;
      latch_q[btn] = 1'b0;
    end
    scan_pos = btn + 1'b1;
    res.channel = chan;
    res.running = run;
    res.serviced_button = btn;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_word(input in_word_t w, input bit has_want, input out_word_t want);
    int        gap;
    out_word_t pred;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0) gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    debounce_tick(w, pred);
    pending_status.push_back(has_want ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CfgUpdownThr:    thr_updown = val;
      CfgStartstopThr: thr_startstop = val;
      CfgChMin:        ch_lo = val;
      CfgChMax:        ch_hi = val;
      CfgChStart:      ch_start = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_word(input in_word_t w, input bit has_want, input out_word_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.word = w;
    row.has_want = has_want;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = val;
    row.word = '1;
    row.has_want = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_status.size() == 0) begin
        flag_mismatch("unexpected word", int'(out_data), 0);
      end else begin
        status_want = pending_status.pop_front();
        if (out_data.channel !== status_want.channel)
          flag_mismatch("channel", int'(out_data.channel), int'(status_want.channel));
        if (out_data.running !== status_want.running)
          flag_mismatch("running", int'(out_data.running), int'(status_want.running));
        if (out_data.serviced_button !== status_want.serviced_button)
          flag_mismatch("serviced_button", int'(out_data.serviced_button),
                        int'(status_want.serviced_button));
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int         sent;
    int         phase;
    int         len;
    int         nwr;
    int         toggle_div;
    logic [3:0] held;
    logic [CfgIdxW-1:0] idx;
    in_word_t   w;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    mismatch_cnt = 0;

    thr_updown = RstUpdownThr;
    thr_startstop = RstStartstopThr;
    ch_lo = RstChMin;
    ch_hi = RstChMax;
    ch_start = RstChStart;
    scan_pos = BtnUp;
    for (int i = 0; i < NumBtn; i++) begin
      press_cnt[i] = '0;
      latch_q[i] = 1'b0;
    end
    chan = ch_start;
    run = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset, nothing is pressed and the start channel shows.
    add_word(4'b1111, 1'b1, {8'd3, 1'b0, BtnUp});
    add_word(4'b1111, 1'b1, {8'd3, 1'b0, BtnDown});
    add_word(4'b1111, 1'b1, {8'd3, 1'b0, BtnStart});
    add_word(4'b1111, 1'b1, {8'd3, 1'b0, BtnStop});
    // With zero thresholds a single press latches; holding it changes nothing.
    add_cfg(CfgUpdownThr, 8'd0);
    add_cfg(CfgStartstopThr, 8'd0);
    repeat (8) add_word(4'b0000, 1'b0, '0);
    repeat (4) add_word(4'b1111, 1'b0, '0);
    // Minimum above maximum: up clamps to the maximum and down from zero to the minimum.
    add_cfg(CfgChMax, 8'd0);
    add_cfg(CfgChMin, 8'd255);
    add_word(4'b0000, 1'b1, {8'd0, 1'b0, BtnUp});
    add_word(4'b0000, 1'b1, {8'd255, 1'b0, BtnDown});
    add_word(4'b0000, 1'b0, '0);
    add_word(4'b0000, 1'b0, '0);
    repeat (4) add_word(4'b1111, 1'b0, '0);
    // Up at full scale, a start channel that must not take effect and an unused index.
    add_cfg(CfgChMax, 8'd255);
    add_cfg(CfgChMin, 8'd0);
    add_cfg(CfgChStart, 8'd200);
    add_cfg(CfgUnused, 8'd77);
    add_word(4'b0111, 1'b1, {8'd255, 1'b0, BtnUp});
    add_word(4'b1011, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].word, plan[i].has_want, plan[i].want);
      end
    end

    sent = 0;
    phase = 0;
    held = '1;
    while (sent < RandomWords) begin
      drain();
      if (phase == 0) begin
        write_reg(CfgUpdownThr, 8'd254);
        write_reg(CfgStartstopThr, 8'd254);
      end
      nwr = $urandom_range(1, 3);
      repeat (nwr) begin
        idx = CfgIdxW'($urandom_range(0, 2 ** CfgIdxW - 1));
        if (idx >= CfgUnused && $urandom_range(0, 3) != 0)
          idx = CfgIdxW'($urandom_range(0, CfgChStart));
        write_reg(idx, pick_reg_value(idx));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      toggle_div = $urandom_range(3, 16);
      len = $urandom_range(30, 110);
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) begin
          w = in_word_t'(4'($urandom_range(0, 15)));
        end else begin
          for (int b = 0; b < NumBtn; b++) begin
            if ($urandom_range(1, toggle_div) == 1) held[b] = !held[b];
          end
          w = in_word_t'(held);
        end
        send_word(w, 1'b0, '0);
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
